@@ sv/lbmc_pkg.sv @@
// ----------------------------------------------------------------------------
// lbmc_pkg: shared types, constants and fixed-point helpers
// Q3.20 data format, D2Q9 lattice tables, request/result structs and the
// rounding and saturating arithmetic used by all collision modules.
// ----------------------------------------------------------------------------
package lbmc_pkg;

  localparam int DATA_W     = 24;
  localparam int FRAC_W     = 20;
  localparam int NDIR       = 9;
  localparam int DIR_IDX_W  = $clog2(NDIR);
  localparam int FLOW_W     = FRAC_W + 1;
  localparam int RATE_W     = FRAC_W + 2;
  localparam int PROD_W     = 2 * DATA_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;
  localparam int SETTLE     = 4;
  localparam int SETTLE_W   = $clog2(SETTLE + 1);
  localparam int PIPE_LAT   = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [FLOW_W-1:0] flow_t;
  typedef logic        [RATE_W-1:0] rate_t;
  typedef logic signed [PROD_W-1:0] wide_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOW_X     = CFG_IDX_W'(0),
    REG_FLOW_Y     = CFG_IDX_W'(1),
    REG_RELAX_RATE = CFG_IDX_W'(2)
  } cfg_reg_t;

  typedef struct packed {
    data_t dist_0;
    data_t dist_1;
    data_t dist_2;
    data_t dist_3;
    data_t dist_4;
    data_t dist_5;
    data_t dist_6;
    data_t dist_7;
    data_t dist_8;
    data_t source_now;
    data_t source_prev;
    logic  wall_cell;
  } req_t;

  typedef struct packed {
    data_t new_dist_0;
    data_t new_dist_1;
    data_t new_dist_2;
    data_t new_dist_3;
    data_t new_dist_4;
    data_t new_dist_5;
    data_t new_dist_6;
    data_t new_dist_7;
    data_t new_dist_8;
    data_t density;
  } res_t;

  // per-cell values shared by all lanes
  typedef struct packed {
    data_t rho;
    data_t src;
    logic  wall;
  } cell_ctl_t;

  // per-direction coefficients derived from the flow registers
  typedef struct packed {
    data_t wpoly;
    data_t wlin;
  } coef_t;

  // lattice directions: rest, +x, +y, -x, -y, +x+y, -x+y, -x-y, +x-y
  localparam logic signed [1:0] DIR_POS = 2'sd1;
  localparam logic signed [1:0] DIR_NEG = -2'sd1;
  localparam logic signed [1:0] DIR_X [NDIR] =
    '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] DIR_Y [NDIR] =
    '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};

  localparam longint W_REST = ((longint'(4) << FRAC_W) + 4) / 9;
  localparam longint W_AXIS = ((longint'(1) << FRAC_W) + 4) / 9;
  localparam longint W_DIAG = ((longint'(1) << FRAC_W) + 18) / 36;

  localparam rate_t RELAX_RESET = rate_t'(((longint'(20) << FRAC_W) + 6) / 13);

  localparam wide_t ONE      = wide_t'(longint'(1) << FRAC_W);
  localparam wide_t HALF_LSB = wide_t'(longint'(1) << (FRAC_W - 1));
  localparam wide_t DMAX     = wide_t'((longint'(1) << (DATA_W - 1)) - 1);
  localparam wide_t DMIN     = -DMAX - wide_t'(1);

  function automatic data_t dir_weight(input logic [DIR_IDX_W-1:0] idx);
    data_t w;
    case (idx)
      DIR_IDX_W'(0): w = data_t'(W_REST);
      DIR_IDX_W'(1),
      DIR_IDX_W'(2),
      DIR_IDX_W'(3),
      DIR_IDX_W'(4): w = data_t'(W_AXIS);
      DIR_IDX_W'(5),
      DIR_IDX_W'(6),
      DIR_IDX_W'(7),
      DIR_IDX_W'(8): w = data_t'(W_DIAG);
      default:       w = '0;
    endcase
    return w;
  endfunction

  // clamp to the signed data range
  function automatic data_t sat_data(input wide_t x);
    data_t r;
    if (x > DMAX) r = DMAX[DATA_W-1:0];
    else if (x < DMIN) r = DMIN[DATA_W-1:0];
    else r = x[DATA_W-1:0];
    return r;
  endfunction

  // round a raw Q.F product to nearest, ties away from zero, then saturate
  function automatic data_t round_mul(input wide_t p);
    wide_t r;
    if (p[PROD_W-1]) r = p + HALF_LSB - wide_t'(1);
    else r = p + HALF_LSB;
    return sat_data(r >>> FRAC_W);
  endfunction

  // halve, ties away from zero
  function automatic wide_t half_away(input wide_t x);
    wide_t r;
    if (x[PROD_W-1]) r = x >>> 1;
    else r = (x + wide_t'(1)) >>> 1;
    return r;
  endfunction

endpackage

@@ sv/lbmc_coef.sv @@
// ----------------------------------------------------------------------------
// lbmc_coef: flow-dependent equilibrium coefficients
// Four-stage pipeline from the flow registers to w_i*poly_i and w_i*lin_i
// for all nine directions. Follows the registers continuously.
// ----------------------------------------------------------------------------
module lbmc_coef (
  input  logic            clk,
  input  lbmc_pkg::flow_t flow_x,
  input  lbmc_pkg::flow_t flow_y,
  output lbmc_pkg::coef_t coef [lbmc_pkg::NDIR]
);
  import lbmc_pkg::*;

  logic signed [2*FLOW_W-1:0] fxx;
  logic signed [2*FLOW_W-1:0] fyy;
  data_t                      uu;

  // u.u, shared by every direction
  always_ff @(posedge clk) begin
    fxx <= flow_x * flow_x;
    fyy <= flow_y * flow_y;
    uu  <= sat_data(wide_t'(round_mul(wide_t'(fxx))) + wide_t'(round_mul(wide_t'(fyy))));
  end

  for (genvar g = 0; g < NDIR; g++) begin : g_dir
    localparam data_t WG = dir_weight(DIR_IDX_W'(g));

    wide_t                      tx;
    wide_t                      ty;
    data_t                      ud_c;
    data_t                      ud;
    data_t                      lin1;
    data_t                      qq;
    data_t                      lin2;
    data_t                      poly;
    data_t                      lin3;
    data_t                      wpoly;
    data_t                      wlin;
    wide_t                      quad_w;
    logic signed [2*DATA_W-1:0] ud_sq;
    logic signed [2*DATA_W-1:0] p_wpoly;
    logic signed [2*DATA_W-1:0] p_wlin;

    always_comb begin
      tx = '0;
      ty = '0;
      if (DIR_X[g] == DIR_POS) tx = wide_t'(flow_x);
      else if (DIR_X[g] == DIR_NEG) tx = -wide_t'(flow_x);
      if (DIR_Y[g] == DIR_POS) ty = wide_t'(flow_y);
      else if (DIR_Y[g] == DIR_NEG) ty = -wide_t'(flow_y);
      ud_c = sat_data(tx + ty);
    end

    assign ud_sq   = ud * ud;
    assign quad_w  = half_away(wide_t'(9) * wide_t'(qq) - wide_t'(3) * wide_t'(uu));
    assign p_wpoly = WG * poly;
    assign p_wlin  = WG * lin3;

    always_ff @(posedge clk) begin
      // u.v_i and 1 + 3 u.v_i
      ud    <= ud_c;
      lin1  <= sat_data(ONE + wide_t'(3) * wide_t'(ud_c));
      // (u.v_i)^2
      qq    <= round_mul(wide_t'(ud_sq));
      lin2  <= lin1;
      // second-order polynomial
      poly  <= sat_data(wide_t'(lin2) + wide_t'(sat_data(quad_w)));
      lin3  <= lin2;
      // weighted
      wpoly <= round_mul(wide_t'(p_wpoly));
      wlin  <= round_mul(wide_t'(p_wlin));
    end

    assign coef[g] = '{wpoly: wpoly, wlin: wlin};
  end

endmodule

@@ sv/lbmc_front.sv @@
// ----------------------------------------------------------------------------
// lbmc_front: density and source front end
// Two-stage saturating density sum over the nine distributions, plus the
// source mix half(3*now - prev). Feeds the per-direction lanes.
// ----------------------------------------------------------------------------
module lbmc_front (
  input  logic                clk,
  input  lbmc_pkg::req_t      req,
  output lbmc_pkg::data_t     f_out [lbmc_pkg::NDIR],
  output lbmc_pkg::cell_ctl_t ctl
);
  import lbmc_pkg::*;

  localparam int HEAD = (NDIR + 1) / 2;

  data_t din [NDIR];
  data_t f1  [NDIR];
  data_t part_c;
  data_t part1;
  data_t rho_c;
  data_t src_c;
  data_t src1;
  logic  wall1;

  always_comb begin
    din[0] = req.dist_0;
    din[1] = req.dist_1;
    din[2] = req.dist_2;
    din[3] = req.dist_3;
    din[4] = req.dist_4;
    din[5] = req.dist_5;
    din[6] = req.dist_6;
    din[7] = req.dist_7;
    din[8] = req.dist_8;
    // sum saturates after every add, in direction order
    part_c = '0;
    for (int i = 0; i < HEAD; i++) begin
      part_c = sat_data(wide_t'(part_c) + wide_t'(din[i]));
    end
    src_c = sat_data(half_away(wide_t'(3) * wide_t'(req.source_now)
                               - wide_t'(req.source_prev)));
  end

  always_comb begin
    rho_c = part1;
    for (int i = HEAD; i < NDIR; i++) begin
      rho_c = sat_data(wide_t'(rho_c) + wide_t'(f1[i]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NDIR; i++) begin
      f1[i]    <= din[i];
      f_out[i] <= f1[i];
    end
    part1    <= part_c;
    src1     <= src_c;
    wall1    <= req.wall_cell;
    ctl.rho  <= rho_c;
    ctl.src  <= src1;
    ctl.wall <= wall1;
  end

endmodule

@@ sv/lbmc_lane.sv @@
// ----------------------------------------------------------------------------
// lbmc_lane: one direction of the BGK collision
// Equilibrium and source term, relaxation product, then final sum and
// wall override. Three register stages.
// ----------------------------------------------------------------------------
module lbmc_lane (
  input  logic                clk,
  input  lbmc_pkg::data_t     f,
  input  lbmc_pkg::cell_ctl_t ctl,
  input  lbmc_pkg::coef_t     coef,
  input  lbmc_pkg::rate_t     relax_rate,
  input  lbmc_pkg::data_t     weight,
  output lbmc_pkg::data_t     new_dist
);
  import lbmc_pkg::*;

  logic signed [2*DATA_W-1:0]      p_feq;
  logic signed [2*DATA_W-1:0]      p_src;
  logic signed [RATE_W+DATA_W:0]   p_rel;
  data_t                           feq;
  data_t                           sterm1;
  data_t                           f1;
  logic                            wall1;
  data_t                           diff;
  logic signed [RATE_W+DATA_W:0]   mrel;
  data_t                           sterm2;
  data_t                           f2;
  logic                            wall2;
  data_t                           relaxed;
  data_t                           sum;

  assign p_feq = ctl.rho * coef.wpoly;
  assign p_src = coef.wlin * ctl.src;
  assign diff  = sat_data(wide_t'(feq) - wide_t'(f1));
  assign p_rel = $signed({1'b0, relax_rate}) * diff;

  assign relaxed = sat_data(wide_t'(f2) + wide_t'(round_mul(wide_t'(mrel))));
  assign sum     = sat_data(wide_t'(relaxed) + wide_t'(sterm2));

  always_ff @(posedge clk) begin
    feq      <= round_mul(wide_t'(p_feq));
    sterm1   <= round_mul(wide_t'(p_src));
    f1       <= f;
    wall1    <= ctl.wall;
    mrel     <= p_rel;
    sterm2   <= sterm1;
    f2       <= f1;
    wall2    <= wall1;
    new_dist <= wall2 ? weight : sum;
  end

endmodule

@@ sv/lbm_d2q9_cell_collision_core.sv @@
// ----------------------------------------------------------------------------
// lbm_d2q9_cell_collision_core: D2Q9 BGK collision, one cell per non-busy clock
// Top level: configuration registers, request pipeline control and the
// nine collision lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req and raise start; the request is taken at any edge
//   where start is high and busy is low. A new cell may be taken every clock.
//   Result: done pulses for one cycle with result valid; it is registered
//   through the front end (2 stages) and the lane (3 stages). The receiver
//   cannot stall; results must be captured in the done cycle.
//   Configuration: write flow_x (0), flow_y (1), relax_rate (2) through
//   cfg_valid/cfg_index/cfg_data; cfg_ready is always high, index 3 sets
//   no register. Write only while no request is in flight.
//   After every write, and after reset, busy stays high while the
//   coefficient pipeline follows the new flow values.
//   Reset (rst, synchronous): registers go to flow 0/0 and rate 20/13, the
//   request pipeline is emptied, busy is high for the settle time.
//   Throughput: one cell per clock unless busy; the lanes are fully pipelined.
// ----------------------------------------------------------------------------
module lbm_d2q9_cell_collision_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  lbmc_pkg::req_t                     req,
  output logic                               done,
  output lbmc_pkg::res_t                     result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lbmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lbmc_pkg::*;

  flow_t                flow_x;
  flow_t                flow_y;
  rate_t                relax_rate;
  logic [SETTLE_W-1:0]  settle;
  logic [PIPE_LAT-1:0]  pipe_v;
  logic                 accept;
  logic                 cfg_wr;

  data_t                f_s2     [NDIR];
  cell_ctl_t            ctl_s2;
  coef_t                coef     [NDIR];
  data_t                lane_out [NDIR];
  data_t                dens3;
  data_t                dens4;
  data_t                dens5;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // busy only while the coefficient pipeline settles
  assign busy      = (settle != '0);
  assign accept    = start && !busy;
  assign done      = pipe_v[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_x     <= '0;
      flow_y     <= '0;
      relax_rate <= RELAX_RESET;
      settle     <= SETTLE_W'(SETTLE);
      pipe_v     <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_FLOW_X:     flow_x     <= cfg_data[FLOW_W-1:0];
          REG_FLOW_Y:     flow_y     <= cfg_data[FLOW_W-1:0];
          REG_RELAX_RATE: relax_rate <= cfg_data[RATE_W-1:0];
          default:        ;
        endcase
        settle <= SETTLE_W'(SETTLE);
      end else if (settle != '0) begin
        settle <= settle - SETTLE_W'(1);
      end
      pipe_v <= {pipe_v[PIPE_LAT-2:0], accept};
    end
  end

  // density travels beside the lanes
  always_ff @(posedge clk) begin
    dens3 <= ctl_s2.rho;
    dens4 <= dens3;
    dens5 <= dens4;
  end

  lbmc_coef u_coef (
    .clk    (clk),
    .flow_x (flow_x),
    .flow_y (flow_y),
    .coef   (coef)
  );

  lbmc_front u_front (
    .clk   (clk),
    .req   (req),
    .f_out (f_s2),
    .ctl   (ctl_s2)
  );

  for (genvar g = 0; g < NDIR; g++) begin : g_lane
    lbmc_lane u_lane (
      .clk        (clk),
      .f          (f_s2[g]),
      .ctl        (ctl_s2),
      .coef       (coef[g]),
      .relax_rate (relax_rate),
      .weight     (dir_weight(DIR_IDX_W'(g))),
      .new_dist   (lane_out[g])
    );
  end

  always_comb begin
    result.new_dist_0 = lane_out[0];
    result.new_dist_1 = lane_out[1];
    result.new_dist_2 = lane_out[2];
    result.new_dist_3 = lane_out[3];
    result.new_dist_4 = lane_out[4];
    result.new_dist_5 = lane_out[5];
    result.new_dist_6 = lane_out[6];
    result.new_dist_7 = lane_out[7];
    result.new_dist_8 = lane_out[8];
    result.density    = dens5;
  end

  // a write must hold off requests while coefficients settle
  a_cfg_holds_off: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("request window open right after a register write");

  // every result strobe has a matching request taken earlier
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without matching request");

  // wall cells give the rest weight on direction 0
  a_wall_rest: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && req.wall_cell, PIPE_LAT))
      |-> (result.new_dist_0 == dir_weight(DIR_IDX_W'(0))))
    else $error("wall cell did not give rest equilibrium");

endmodule
